### rtl/core/radial_aev_accumulator_defines.svh
// Assertion macros used by the checker of the radial accumulator.
`ifndef RADIAL_AEV_ACCUMULATOR_DEFINES_SVH
`define RADIAL_AEV_ACCUMULATOR_DEFINES_SVH

// Consequent in the cycle after the antecedent.
`define RAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Consequent in the same cycle as the antecedent.
`define RAE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/rae_pkg.sv
package rae_pkg;

  // Store geometry; the word fields are sized for these.
  localparam int RAE_MAX_ATOMS = 64;
  localparam int RAE_SPECIES   = 4;
  localparam int RAE_SHIFTS    = 16;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } rae_action_t;

  typedef enum logic [1:0] {
    REG_CUTOFF = 2'd0,
    REG_ETA    = 2'd1,
    REG_START  = 2'd2,
    REG_STEP   = 2'd3
  } rae_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_NOP,
    ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_RANGE_MUL, ST_RANGE,
    ST_ROOT, ST_DIV, ST_FC_MUL, ST_FC_SET,
    ST_T_Q, ST_T_E, ST_T_L, ST_T_P, ST_T_G, ST_T_T,
    ST_RD1, ST_WR1, ST_RD2, ST_WR2,
    ST_RD_ADDR, ST_RD_DATA
  } rae_state_t;

  // Control from the sequencer to the root/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } rae_ctl_t;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam int          ROOT_STEPS = 32;
  localparam int          DIV_STEPS  = 17;

  // 0.5*cos(pi*k/16)+0.5 in Q16.
  function automatic logic [16:0] fc_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd64906;
      5'd2:  v = 17'd63042;
      5'd3:  v = 17'd60014;
      5'd4:  v = 17'd55938;
      5'd5:  v = 17'd50973;
      5'd6:  v = 17'd45308;
      5'd7:  v = 17'd39161;
      5'd8:  v = 17'd32768;
      5'd9:  v = 17'd26375;
      5'd10: v = 17'd20228;
      5'd11: v = 17'd14563;
      5'd12: v = 17'd9598;
      5'd13: v = 17'd5522;
      5'd14: v = 17'd2494;
      5'd15: v = 17'd630;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // 2^(-k/16) in Q16.
  function automatic logic [16:0] pow_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/rae_channels.sv
interface rae_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [5:0]        atom_first;
  logic [5:0]        atom_second;
  logic [2:0]        species_first;
  logic [2:0]        species_second;
  logic [3:0]        shift_select;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [15:0] delta_z;

  modport source (output valid, action, atom_first, atom_second, species_first,
                  species_second, shift_select, delta_x, delta_y, delta_z,
                  input ready);
  modport sink (input valid, action, atom_first, atom_second, species_first,
                species_second, shift_select, delta_x, delta_y, delta_z,
                output ready);
  modport mon (input valid, ready, action, atom_first, atom_second, species_first,
               species_second, shift_select, delta_x, delta_y, delta_z);
endinterface

interface rae_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] term_sum;

  modport source (output valid, term_sum, input ready);
  modport sink (input valid, term_sum, output ready);
  modport mon (input valid, ready, term_sum);
endinterface

### rtl/core/rae_ram.sv
module rae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### rtl/core/rae_mul.sv
module rae_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end
endmodule

### rtl/core/rae_root_div.sv
module rae_root_div
  import rae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rae_ctl_t    ctl,
  input  logic [31:0] opnd,
  input  logic [14:0] divisor,
  output logic        done_r,
  output logic [31:0] result
);
  logic [63:0] src_r, src_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_nxt;
  logic        div_r, div_nxt;
  logic [35:0] rem_sh, trial;
  logic        ge;

  // One compare-subtract serves both the root and the division step.
  always_comb begin
    if (div_r) begin
      rem_sh = {rem_r[34:0], src_r[63]};
      trial  = {21'd0, divisor};
    end else begin
      rem_sh = {rem_r[33:0], src_r[63:62]};
      trial  = {2'b00, root_r, 2'b01};
    end
    ge = (rem_sh >= trial);
  end

  always_comb begin
    src_nxt  = src_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      div_nxt  = ctl.is_div;
      root_nxt = '0;
      if (ctl.is_div) begin
        src_nxt = {opnd[16:0], 47'd0};
        rem_nxt = {21'd0, opnd[31:17]};
        cnt_nxt = 6'(DIV_STEPS);
      end else begin
        src_nxt = {opnd, 32'd0};
        rem_nxt = '0;
        cnt_nxt = 6'(ROOT_STEPS);
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[30:0], ge};
      src_nxt  = div_r ? {src_r[62:0], 1'b0} : {src_r[61:0], 2'b00};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    src_r  <= src_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    div_r  <= div_nxt;
  end

  assign result = root_r;
endmodule

### rtl/core/radial_aev_accumulator.sv
// Radial environment accumulator. One word is taken at a time; in_ch.ready is
// high only while the sequencer is idle. For an accumulate word the shared 32x32
// multiplier forms the squares, the interpolations and each radial term, a
// one-bit-per-cycle unit takes the square root (32 steps) and the cutoff ratio
// (17 steps), and each of the RAE_SHIFTS terms costs two read-modify-write
// passes on the store. A skipped pair and action 3 return to idle without
// touching the store; a read waits while an earlier result is still held in
// the result register. After reset, and on every clear word, the store is
// swept to zero at one entry a cycle, all RAE_MAX_ATOMS*RAE_SPECIES*RAE_SHIFTS
// entries (4096), during which no word is taken. Configuration writes take
// effect at once; make them only while the block is idle.
module radial_aev_accumulator
  import rae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rae_in_if.sink      in_ch,
  rae_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  localparam int DEPTH = RAE_MAX_ATOMS * RAE_SPECIES * RAE_SHIFTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(RAE_SHIFTS + 1);

  rae_state_t state_r, state_nxt;

  logic [14:0] rc_r;
  logic [7:0]  eta_r;
  logic [14:0] start_r;
  logic [11:0] step_r;

  logic [5:0]  a1_r, a2_r;
  logic [2:0]  s1_r, s2_r;
  logic [3:0]  sh_r;
  logic [15:0] dx_r, dy_r, dz_r;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] d16_r, d16_nxt;
  logic [16:0] t_r, t_nxt;
  logic [16:0] fc_r, fc_nxt;
  logic [18:0] s_r, s_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic        gbig_r, gbig_nxt;
  logic        xoff_r, xoff_nxt;
  logic [3:0]  seg_r, seg_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [15:0] term_r, term_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_r, out_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  rae_ctl_t    rd_ctl;
  logic [31:0] rd_opnd;
  logic        rd_done;
  logic [31:0] rd_result;

  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [31:0]   ram_wd, ram_rd;

  logic [34:0] diff;
  logic [22:0] q;
  logic [27:0] xq;
  logic [20:0] yq;
  logic [16:0] interp, gval;
  logic [32:0] sum;
  logic [31:0] sum_sat;
  logic        accept, take_out, rd_ok;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [5:0] atom, input logic [2:0] sp,
                                            input logic [31:0] sh);
    logic [31:0] v;
    v = ({26'd0, atom} * RAE_SPECIES + {29'd0, sp}) * RAE_SHIFTS + sh;
    return v[AW-1:0];
  endfunction

  rae_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));

  rae_root_div u_root_div (
    .clk(clk), .rst_n(rst_n), .ctl(rd_ctl), .opnd(rd_opnd), .divisor(rc_r),
    .done_r(rd_done), .result(rd_result)
  );

  rae_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign take_out = out_ch.ready || !out_valid_r;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.term_sum = out_r;

  assign rd_ok = ({26'd0, a1_r} < RAE_MAX_ATOMS) && ({29'd0, s1_r} < RAE_SPECIES)
                 && ({28'd0, sh_r} < RAE_SHIFTS);

  // Datapath pieces of one radial term.
  always_comb begin
    logic [34:0] s16, d35;
    s16    = {s_r, 16'd0};
    d35    = {3'd0, d16_r};
    diff   = (s16 > d35) ? (s16 - d35) : (d35 - s16);
    q      = diff[34:12];
    xq     = prod[39:12];
    yq     = prod[36:16];
    interp = pow_tab({1'b0, seg_r}) - prod[28:12];
    gval   = xoff_r ? 17'd0 : (interp >> n_r);
    sum    = {1'b0, ram_rd} + {17'd0, term_r};
    sum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r;
    d16_nxt = d16_r;
    t_nxt = t_r;
    fc_nxt = fc_r;
    s_nxt = s_r;
    i_nxt = i_r;
    gbig_nxt = gbig_r;
    xoff_nxt = xoff_r;
    seg_nxt = seg_r;
    n_nxt = n_r;
    term_nxt = term_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt = out_r;
    mul_a = '0;
    mul_b = '0;
    rd_ctl = '0;
    rd_opnd = acc_r;
    ram_we = 1'b0;
    ram_wa = clr_r;
    ram_wd = '0;
    ram_ra = addr_of(a1_r, s2_r, {{(32-CW){1'b0}}, i_r});

    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (rae_action_t'(in_ch.action))
            ACT_ACCUM: begin
              if ((32'(in_ch.species_first) >= RAE_SPECIES)
                  || (32'(in_ch.species_second) >= RAE_SPECIES) || (rc_r == '0)) begin
                state_nxt = ST_NOP;
              end else begin
                state_nxt = ST_SQ_X;
              end
            end
            ACT_READ:  state_nxt = ST_RD_ADDR;
            ACT_CLEAR: begin
              clr_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            default:   state_nxt = ST_NOP;
          endcase
        end
      end
      ST_NOP: state_nxt = ST_IDLE;
      ST_SQ_X: begin
        mul_a = {16'd0, mag16(dx_r)};
        mul_b = {16'd0, mag16(dx_r)};
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        acc_nxt = prod[31:0];
        mul_a = {16'd0, mag16(dy_r)};
        mul_b = {16'd0, mag16(dy_r)};
        state_nxt = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        acc_nxt = acc_r + prod[31:0];
        mul_a = {16'd0, mag16(dz_r)};
        mul_b = {16'd0, mag16(dz_r)};
        state_nxt = ST_RANGE_MUL;
      end
      ST_RANGE_MUL: begin
        acc_nxt = acc_r + prod[31:0];
        mul_a = {17'd0, rc_r};
        mul_b = {17'd0, rc_r};
        state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        if (acc_r > prod[31:0]) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_ctl.start = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rd_done) begin
          d16_nxt = rd_result;
          rd_ctl.start = 1'b1;
          rd_ctl.is_div = 1'b1;
          rd_opnd = rd_result;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rd_done) begin
          t_nxt = rd_result[16:0];
          state_nxt = ST_FC_MUL;
        end
      end
      ST_FC_MUL: begin
        mul_a = {15'd0, fc_tab({1'b0, t_r[15:12]}) - fc_tab({1'b0, t_r[15:12]} + 5'd1)};
        mul_b = {20'd0, t_r[11:0]};
        state_nxt = ST_FC_SET;
      end
      ST_FC_SET: begin
        fc_nxt = t_r[16] ? fc_tab(5'd16) : (fc_tab({1'b0, t_r[15:12]}) - prod[28:12]);
        s_nxt = {4'd0, start_r};
        i_nxt = '0;
        state_nxt = ST_T_Q;
      end
      ST_T_Q: begin
        gbig_nxt = (q[22:16] != '0) && (eta_r != '0);
        mul_a = {16'd0, q[15:0]};
        mul_b = {16'd0, q[15:0]};
        state_nxt = ST_T_E;
      end
      ST_T_E: begin
        mul_a = {24'd0, eta_r};
        mul_b = prod[31:0];
        state_nxt = ST_T_L;
      end
      ST_T_L: begin
        xoff_nxt = gbig_r || (xq[27:20] != '0);
        mul_a = {12'd0, xq[19:0]};
        mul_b = {15'd0, LOG2E_Q16};
        state_nxt = ST_T_P;
      end
      ST_T_P: begin
        seg_nxt = yq[15:12];
        n_nxt = yq[20:16];
        mul_a = {15'd0, pow_tab({1'b0, yq[15:12]}) - pow_tab({1'b0, yq[15:12]} + 5'd1)};
        mul_b = {20'd0, yq[11:0]};
        state_nxt = ST_T_G;
      end
      ST_T_G: begin
        mul_a = {15'd0, gval};
        mul_b = {15'd0, fc_r};
        state_nxt = ST_T_T;
      end
      ST_T_T: begin
        term_nxt = prod[33:18];
        state_nxt = ST_RD1;
      end
      ST_RD1: state_nxt = ST_WR1;
      ST_WR1: begin
        ram_we = ({26'd0, a1_r} < RAE_MAX_ATOMS);
        ram_wa = addr_of(a1_r, s2_r, {{(32-CW){1'b0}}, i_r});
        ram_wd = sum_sat;
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        ram_ra = addr_of(a2_r, s1_r, {{(32-CW){1'b0}}, i_r});
        state_nxt = ST_WR2;
      end
      ST_WR2: begin
        ram_we = ({26'd0, a2_r} < RAE_MAX_ATOMS);
        ram_wa = addr_of(a2_r, s1_r, {{(32-CW){1'b0}}, i_r});
        ram_wd = sum_sat;
        if (i_r == CW'(RAE_SHIFTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + CW'(1);
          s_nxt = s_r + {7'd0, step_r};
          state_nxt = ST_T_Q;
        end
      end
      ST_RD_ADDR: begin
        ram_ra = addr_of(a1_r, s1_r, {28'd0, sh_r});
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        ram_ra = addr_of(a1_r, s1_r, {28'd0, sh_r});
        // hold until the output register is free
        if (take_out) begin
          out_valid_nxt = 1'b1;
          out_nxt = rd_ok ? ram_rd : 32'd0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      i_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      i_r <= i_nxt;
    end
    acc_r <= acc_nxt;
    d16_r <= d16_nxt;
    t_r <= t_nxt;
    fc_r <= fc_nxt;
    s_r <= s_nxt;
    gbig_r <= gbig_nxt;
    xoff_r <= xoff_nxt;
    seg_r <= seg_nxt;
    n_r <= n_nxt;
    term_r <= term_nxt;
    out_r <= out_nxt;
  end

  // Latch the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      a1_r <= in_ch.atom_first;
      a2_r <= in_ch.atom_second;
      s1_r <= in_ch.species_first;
      s2_r <= in_ch.species_second;
      sh_r <= in_ch.shift_select;
      dx_r <= in_ch.delta_x;
      dy_r <= in_ch.delta_y;
      dz_r <= in_ch.delta_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= 15'd5325;
      eta_r <= 8'd16;
      start_r <= 15'd922;
      step_r <= 12'd275;
    end else if (cfg_we) begin
      unique case (rae_reg_t'(cfg_index))
        REG_CUTOFF: rc_r <= cfg_data;
        REG_ETA:    eta_r <= cfg_data[7:0];
        REG_START:  start_r <= cfg_data;
        REG_STEP:   step_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/rae_checker.sv
`include "radial_aev_accumulator_defines.svh"

module rae_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_term_sum
);
  // a taken word always keeps the sequencer busy for the next cycle
  `RAE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after a word was taken")
  // a result appears only while the sequencer is working
  `RAE_ASSERT_NEXT(a_result_from_work, clk, rst_n, !out_valid && in_ready, !out_valid, "result appeared out of an idle sequencer")
  `RAE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_term_sum), "stalled result changed or dropped")
endmodule

bind radial_aev_accumulator rae_checker u_rae_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_term_sum(out_ch.term_sum)
);
